@@ rtl/lli_pkg.sv @@
`timescale 1ns / 1ps

package lli_pkg;

    // coordinate format shared by both lines and the result
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_START_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_START_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_END_X   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_END_Y   = 3'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] probe_start_x;
        logic signed [COORD_WIDTH-1:0] probe_start_y;
        logic signed [COORD_WIDTH-1:0] probe_end_x;
        logic signed [COORD_WIDTH-1:0] probe_end_y;
    } lli_in_t;

    typedef struct packed {
        logic                          valid_res;
        logic signed [COORD_WIDTH-1:0] cross_x;
        logic signed [COORD_WIDTH-1:0] cross_y;
        logic                          clipped;
    } lli_out_t;

    // per-request data carried alongside the divider
    typedef struct packed {
        logic                          zero;
        logic                          neg;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [DIFF_W-1:0]      pdx;
        logic signed [DIFF_W-1:0]      pdy;
    } lli_side_t;

endpackage

@@ rtl/line_line_intersection.sv @@
// the divider resolves one quotient bit per pipeline stage
// throughput: one request per cycle; the whole pipeline holds while a result waits
// reset: synchronous active-low aresetn clears all stage valid bits and the
// reference line registers to zero
`timescale 1ns / 1ps

module line_line_intersection #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lli_pkg::lli_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lli_pkg::lli_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [lli_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lli_pkg::COORD_WIDTH-1:0]     cfg_data
);

    localparam int W    = lli_pkg::COORD_WIDTH;
    localparam int DW   = lli_pkg::DIFF_W;
    localparam int PRW  = 2 * DW;
    localparam int SW   = PRW + 1;
    localparam int MW   = PRW;
    localparam int R    = RATIO_FRAC_BITS;
    localparam int NDW  = MW + R;
    localparam int QB   = R + W + 2;
    localparam int RW   = QB + 1;
    localparam int PW   = RW + DW;
    localparam int OW   = PW - R;
    localparam int SATW = OW + 1;
    localparam int SIDE_W = $bits(lli_pkg::lli_side_t);

    localparam logic [QB-1:0] R_LIM = {1'b1, {(QB-1){1'b0}}};

    logic adv;

    // reference line registers
    logic signed [W-1:0] ref_cx_reg, ref_cy_reg, ref_dx_reg, ref_dy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_cx_reg <= '0;
            ref_cy_reg <= '0;
            ref_dx_reg <= '0;
            ref_dy_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lli_pkg::REG_REF_START_X: ref_cx_reg <= $signed(cfg_data);
                lli_pkg::REG_REF_START_Y: ref_cy_reg <= $signed(cfg_data);
                lli_pkg::REG_REF_END_X:   ref_dx_reg <= $signed(cfg_data);
                lli_pkg::REG_REF_END_Y:   ref_dy_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // global stage enable: move when the output register is free or taken
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic div_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= div_valid;
            v6_reg      <= v5_reg;
            m_valid_reg <= v6_reg;
        end
    end

    // stage 1: coordinate differences
    logic signed [W-1:0]  ax_s1_reg, ay_s1_reg;
    logic signed [DW-1:0] pdx_s1_reg, pdy_s1_reg, rdx_s1_reg, rdy_s1_reg;
    logic signed [DW-1:0] acx_s1_reg, acy_s1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_s1_reg  <= s_data.probe_start_x;
            ay_s1_reg  <= s_data.probe_start_y;
            pdx_s1_reg <= DW'(s_data.probe_end_x) - DW'(s_data.probe_start_x);
            pdy_s1_reg <= DW'(s_data.probe_end_y) - DW'(s_data.probe_start_y);
            rdx_s1_reg <= DW'(ref_dx_reg) - DW'(ref_cx_reg);
            rdy_s1_reg <= DW'(ref_dy_reg) - DW'(ref_cy_reg);
            acx_s1_reg <= DW'(s_data.probe_start_x) - DW'(ref_cx_reg);
            acy_s1_reg <= DW'(s_data.probe_start_y) - DW'(ref_cy_reg);
        end
    end

    // stage 2: cross products
    logic signed [W-1:0]   ax_s2_reg, ay_s2_reg;
    logic signed [DW-1:0]  pdx_s2_reg, pdy_s2_reg;
    logic signed [PRW-1:0] den_a_s2_reg, den_b_s2_reg, num_a_s2_reg, num_b_s2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_s2_reg    <= ax_s1_reg;
            ay_s2_reg    <= ay_s1_reg;
            pdx_s2_reg   <= pdx_s1_reg;
            pdy_s2_reg   <= pdy_s1_reg;
            den_a_s2_reg <= PRW'(pdx_s1_reg) * PRW'(rdy_s1_reg);
            den_b_s2_reg <= PRW'(pdy_s1_reg) * PRW'(rdx_s1_reg);
            num_a_s2_reg <= PRW'(acy_s1_reg) * PRW'(rdx_s1_reg);
            num_b_s2_reg <= PRW'(acx_s1_reg) * PRW'(rdy_s1_reg);
        end
    end

    // stage 3: denominator and numerator
    logic signed [W-1:0]  ax_s3_reg, ay_s3_reg;
    logic signed [DW-1:0] pdx_s3_reg, pdy_s3_reg;
    logic signed [SW-1:0] den_s3_reg, num_s3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_s3_reg  <= ax_s2_reg;
            ay_s3_reg  <= ay_s2_reg;
            pdx_s3_reg <= pdx_s2_reg;
            pdy_s3_reg <= pdy_s2_reg;
            den_s3_reg <= SW'(den_a_s2_reg) - SW'(den_b_s2_reg);
            num_s3_reg <= SW'(num_a_s2_reg) - SW'(num_b_s2_reg);
        end
    end

    // stage 4: magnitudes, quotient sign, parallel test
    logic signed [SW-1:0] den_neg, num_neg;
    logic [MW-1:0]        den_mag, num_mag;
    lli_pkg::lli_side_t   side_s4_reg;
    logic [MW-1:0]        den_mag_s4_reg;
    logic [NDW-1:0]       num_sh_s4_reg;

    assign den_neg = -den_s3_reg;
    assign num_neg = -num_s3_reg;
    assign den_mag = den_s3_reg[SW-1] ? den_neg[MW-1:0] : den_s3_reg[MW-1:0];
    assign num_mag = num_s3_reg[SW-1] ? num_neg[MW-1:0] : num_s3_reg[MW-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_s4_reg.zero <= den_s3_reg == '0;
            side_s4_reg.neg  <= den_s3_reg[SW-1] ^ num_s3_reg[SW-1];
            side_s4_reg.ax   <= ax_s3_reg;
            side_s4_reg.ay   <= ay_s3_reg;
            side_s4_reg.pdx  <= pdx_s3_reg;
            side_s4_reg.pdy  <= pdy_s3_reg;
            den_mag_s4_reg   <= den_mag;
            num_sh_s4_reg    <= {num_mag, {R{1'b0}}};
        end
    end

    // ratio divider
    logic [QB-1:0]      div_quot;
    logic               div_ovf;
    lli_pkg::lli_side_t div_side;

    lli_div #(
        .MW     (MW),
        .NDW    (NDW),
        .QB     (QB),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v4_reg),
        .in_num    (num_sh_s4_reg),
        .in_den    (den_mag_s4_reg),
        .in_side   (side_s4_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_ovf   (div_ovf),
        .out_side  (div_side)
    );

    // stage 5: clamp ratio magnitude and apply sign
    logic [QB-1:0]        r_mag;
    logic signed [RW-1:0] r_pos;
    logic signed [RW-1:0] r_s5_reg;
    lli_pkg::lli_side_t   side_s5_reg;

    assign r_mag = (div_ovf || div_quot > R_LIM) ? R_LIM : div_quot;
    assign r_pos = $signed({1'b0, r_mag});

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_s5_reg    <= div_side.neg ? -r_pos : r_pos;
            side_s5_reg <= div_side;
        end
    end

    // stage 6: offsets along the probe line
    logic signed [PW-1:0] ox_s6_reg, oy_s6_reg;
    lli_pkg::lli_side_t   side_s6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_s6_reg   <= PW'(r_s5_reg) * PW'(side_s5_reg.pdx);
            oy_s6_reg   <= PW'(r_s5_reg) * PW'(side_s5_reg.pdy);
            side_s6_reg <= side_s5_reg;
        end
    end

    // stage 7: floor shift, add start point, saturate
    logic signed [OW-1:0]   ofs_x, ofs_y;
    logic signed [SATW-1:0] sum_x, sum_y;
    logic                   clip_x, clip_y;
    logic signed [W-1:0]    sat_x, sat_y;
    lli_pkg::lli_out_t      res_next;
    lli_pkg::lli_out_t      m_data_reg;

    assign ofs_x  = $signed(ox_s6_reg[PW-1:R]);
    assign ofs_y  = $signed(oy_s6_reg[PW-1:R]);
    assign sum_x  = SATW'(ofs_x) + SATW'(side_s6_reg.ax);
    assign sum_y  = SATW'(ofs_y) + SATW'(side_s6_reg.ay);
    assign clip_x = !((&sum_x[SATW-1:W-1]) || !(|sum_x[SATW-1:W-1]));
    assign clip_y = !((&sum_y[SATW-1:W-1]) || !(|sum_y[SATW-1:W-1]));
    assign sat_x  = clip_x ? (sum_x[SATW-1] ? lli_pkg::COORD_MIN : lli_pkg::COORD_MAX)
                           : sum_x[W-1:0];
    assign sat_y  = clip_y ? (sum_y[SATW-1] ? lli_pkg::COORD_MIN : lli_pkg::COORD_MAX)
                           : sum_y[W-1:0];

    always_comb begin
        if (side_s6_reg.zero) begin
            res_next = '0;
        end else begin
            res_next.valid_res = 1'b1;
            res_next.cross_x   = sat_x;
            res_next.cross_y   = sat_y;
            res_next.clipped   = clip_x || clip_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= res_next;
        end
    end

    assign m_data = m_data_reg;

endmodule

@@ rtl/lli_div.sv @@
`timescale 1ns / 1ps

// pipelined restoring divider on magnitudes, one quotient bit per stage
module lli_div #(
    parameter int MW     = 34,
    parameter int NDW    = 50,
    parameter int QB     = 34,
    parameter int SIDE_W = 70
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NDW-1:0]    in_num,
    input  logic [MW-1:0]     in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [QB-1:0]     out_quot,
    output logic              out_ovf,
    output logic [SIDE_W-1:0] out_side
);

    localparam int CW = MW + QB;

    logic              vld_reg  [0:QB];
    logic              ovf_reg  [0:QB];
    logic [NDW-1:0]    rem_reg  [0:QB];
    logic [MW-1:0]     den_reg  [0:QB];
    logic [QB-1:0]     quot_reg [0:QB];
    logic [SIDE_W-1:0] side_reg [0:QB];

    logic [CW-1:0] num_ext;
    logic [CW-1:0] den_top;
    logic          ovf_next;

    // quotient too large for the kept bits
    assign num_ext  = {{(CW-NDW){1'b0}}, in_num};
    assign den_top  = {in_den, {QB{1'b0}}};
    assign ovf_next = num_ext >= den_top;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0]  <= ovf_next;
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quot_reg[0] <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [CW-1:0]  rem_ext;
        logic [CW-1:0]  den_sh;
        logic [CW-1:0]  diff;
        logic           take;
        logic [NDW-1:0] rem_next;

        // compare and subtract the divisor at this bit weight
        assign rem_ext  = {{(CW-NDW){1'b0}}, rem_reg[k]};
        assign den_sh   = {{QB{1'b0}}, den_reg[k]} << (QB - 1 - k);
        assign take     = rem_ext >= den_sh;
        assign diff     = rem_ext - den_sh;
        assign rem_next = take ? diff[NDW-1:0] : rem_reg[k];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[k+1]  <= ovf_reg[k];
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_reg[k];
                quot_reg[k+1] <= {quot_reg[k][QB-2:0], take};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_quot  = quot_reg[QB];
    assign out_ovf   = ovf_reg[QB];
    assign out_side  = side_reg[QB];

endmodule

@@ rtl/lli_check.sv @@
`timescale 1ns / 1ps

module lli_check (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input lli_pkg::lli_out_t m_data
);

    // a waiting result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the pipeline takes no request while a result is stalled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("request taken during output stall");

    // parallel lines give an all-zero result
    a_parallel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |->
            m_data.cross_x == '0 && m_data.cross_y == '0 && !m_data.clipped)
        else $error("parallel result not zero");

    // a clipped result sits on a range end
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.clipped |->
            m_data.cross_x == lli_pkg::COORD_MAX || m_data.cross_x == lli_pkg::COORD_MIN ||
            m_data.cross_y == lli_pkg::COORD_MAX || m_data.cross_y == lli_pkg::COORD_MIN)
        else $error("clipped flag without saturated coordinate");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind line_line_intersection lli_check u_lli_check (.*);
